// ----- rtl/core/mmms_pkg.sv -----
package mmms_pkg;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               final_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] minimum;
    logic signed [23:0] maximum;
    logic signed [23:0] average;
    logic        [23:0] deviation;
    logic               overflowed;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_MEAN,
    ST_SQUARE,
    ST_VAR,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // take in accepted sample
    logic div_start;  // start a divide (mean or variance)
    logic sq_start;   // start square pass
    logic var_sel;    // divide selects square sum
    logic root_start;
    logic finish;     // latch result and clear set
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sq_done;
    logic root_done;
    logic last_seen;
  } stat_t;

  localparam logic signed [23:0] MostPositive = 24'sh7FFFFF;
  localparam logic signed [23:0] MostNegative = 24'sh800000;

endpackage

// ----- rtl/core/min_max_mean_stddev_unit.sv -----
// Population min/max/mean/standard deviation over a set of signed Q8.16
// samples. Each sample takes one cycle while loading. After the last sample
// the block stalls its input while it starts, runs a 64-step shift-subtract
// divide for the mean, makes a pass over the sample RAM through a
// read/subtract/square/accumulate pipe, runs a second 64-step divide for
// the variance and a 32-step square root, and offers the result. The
// result waits in its register until taken. Samples past MAX_SAMPLES are
// dropped and flagged.
module min_max_mean_stddev_unit #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmms_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mmms_pkg::out_item_t out_data
);

  mmms_pkg::cmd_t  cmd;
  mmms_pkg::stat_t stat;

  mmms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mmms_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_data)
  );

endmodule

// ----- rtl/core/mmms_ram.sv -----
module mmms_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mmms_ctrl.sv -----
module mmms_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mmms_pkg::stat_t stat,
  output mmms_pkg::cmd_t  cmd
);

  mmms_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmms_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      mmms_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.last_seen) begin
            state_next = mmms_pkg::ST_DIV;
          end
        end
      end
      // count and sum include the final request from here on, unless it was dropped
      mmms_pkg::ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = mmms_pkg::ST_MEAN;
      end
      mmms_pkg::ST_MEAN: begin
        if (stat.div_done) begin
          cmd.sq_start = 1'b1;
          state_next   = mmms_pkg::ST_SQUARE;
        end
      end
      mmms_pkg::ST_SQUARE: begin
        if (stat.sq_done) begin
          cmd.div_start = 1'b1;
          cmd.var_sel   = 1'b1;
          state_next    = mmms_pkg::ST_VAR;
        end
      end
      mmms_pkg::ST_VAR: begin
        cmd.var_sel = 1'b1;
        if (stat.div_done) begin
          cmd.root_start = 1'b1;
          state_next     = mmms_pkg::ST_ROOT;
        end
      end
      mmms_pkg::ST_ROOT: begin
        if (stat.root_done) begin
          cmd.finish = 1'b1;
          state_next = mmms_pkg::ST_OUT;
        end
      end
      mmms_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = mmms_pkg::ST_LOAD;
        end
      end
      default: state_next = mmms_pkg::ST_LOAD;
    endcase
  end

endmodule

// ----- rtl/core/mmms_datapath.sv -----
module mmms_datapath #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  mmms_pkg::in_item_t  in_item,
  input  mmms_pkg::cmd_t      cmd,
  output mmms_pkg::stat_t     stat,
  output mmms_pkg::out_item_t out_item
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] Full = CW'(MAX_SAMPLES);

  logic [CW-1:0]      count;
  logic signed [23:0] run_min, run_max;
  logic signed [34:0] run_sum;
  logic               dropped;
  logic               div_done, sq_done, root_done;

  wire store_ok = (count != Full);
  wire do_store = cmd.load && store_ok;

  assign stat = '{div_done: div_done, sq_done: sq_done, root_done: root_done,
                  last_seen: in_item.final_sample};

  // --- square pass addressing
  logic [CW-1:0] rd_idx;
  logic          sq_run, rd_pend;
  logic [23:0]   rd_data;

  mmms_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (count[AW-1:0]),
    .wdata (in_item.sample),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      count   <= '0;
      run_min <= mmms_pkg::MostPositive;
      run_max <= mmms_pkg::MostNegative;
      run_sum <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (store_ok) begin
        count   <= count + 1'b1;
        run_sum <= run_sum + 35'(in_item.sample);
        if (in_item.sample < run_min) run_min <= in_item.sample;
        if (in_item.sample > run_max) run_max <= in_item.sample;
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // --- shared restoring divider, 64-bit magnitude by count
  logic [63:0]        dv_rem_q;  // quotient bits shift in here
  logic [CW:0]        dv_rem;
  logic [6:0]         dv_cnt;
  logic               dv_busy, dv_neg;
  logic signed [23:0] mean;
  logic [63:0]        sq_sum;
  logic [63:0]        dv_num;
  logic [CW:0]        dv_trial;

  always_comb begin
    if (cmd.var_sel) begin
      dv_num = sq_sum;
    end else begin
      dv_num = run_sum[34] ? 64'(-run_sum) : 64'(run_sum);
    end
  end

  assign dv_trial = {dv_rem[CW-1:0], dv_rem_q[63]};

  always_ff @(posedge clk) begin
    div_done <= 1'b0;
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (cmd.div_start) begin
      dv_busy  <= (count != '0);
      dv_rem_q <= dv_num;
      dv_rem   <= '0;
      dv_cnt   <= '0;
      dv_neg   <= !cmd.var_sel && run_sum[34];
      if (count == '0) div_done <= 1'b1;
    end else if (dv_busy) begin
      if (dv_trial >= {1'b0, count}) begin
        dv_rem   <= dv_trial - {1'b0, count};
        dv_rem_q <= {dv_rem_q[62:0], 1'b1};
      end else begin
        dv_rem   <= dv_trial;
        dv_rem_q <= {dv_rem_q[62:0], 1'b0};
      end
      dv_cnt <= dv_cnt + 1'b1;
      if (dv_cnt == 7'd63) begin
        dv_busy  <= 1'b0;
        div_done <= 1'b1;
      end
    end else if (div_done == 1'b0 && dv_cnt == 7'd64) begin
      dv_cnt <= '0;
    end
  end

  // mean captured in the cycle after the last step; the variance is read
  // straight from the quotient by the square root
  always_ff @(posedge clk) begin
    if (div_done && !cmd.var_sel) begin
      mean <= dv_neg ? -24'(dv_rem_q) : 24'(dv_rem_q);
    end
  end

  // --- square pass: read, subtract, multiply, accumulate
  logic        d_vld, m_vld;
  logic [24:0] d_mag;
  logic [49:0] m_prod;

  always_ff @(posedge clk) begin
    sq_done <= 1'b0;
    if (rst) begin
      sq_run  <= 1'b0;
      rd_pend <= 1'b0;
      d_vld   <= 1'b0;
      m_vld   <= 1'b0;
    end else begin
      if (cmd.sq_start) begin
        sq_run <= (count != '0);
        rd_idx <= '0;
        sq_sum <= '0;
        if (count == '0) sq_done <= 1'b1;
      end else if (sq_run) begin
        rd_idx <= rd_idx + 1'b1;
        if (rd_idx == count - 1'b1) sq_run <= 1'b0;
      end
      rd_pend <= sq_run;
      d_vld   <= rd_pend;
      m_vld   <= d_vld;
      if (rd_pend) begin
        logic signed [24:0] d;
        d = 25'($signed(rd_data)) - 25'(mean);
        d_mag <= d[24] ? 25'(-d) : 25'(d);
      end
      if (d_vld) m_prod <= d_mag * d_mag;
      if (m_vld) sq_sum <= sq_sum + 64'(m_prod);
      if (m_vld && !d_vld) sq_done <= 1'b1;
    end
  end

  // --- bitwise integer square root, one result bit per step
  logic [63:0] rt_n, rt_root, rt_bit;
  logic        rt_busy;
  logic [31:0] root;

  always_ff @(posedge clk) begin
    root_done <= 1'b0;
    if (rst) begin
      rt_busy <= 1'b0;
    end else if (cmd.root_start) begin
      rt_busy <= 1'b1;
      rt_n    <= dv_rem_q;
      rt_root <= '0;
      rt_bit  <= 64'h4000_0000_0000_0000;
    end else if (rt_busy) begin
      if (rt_n >= rt_root + rt_bit) begin
        rt_n    <= rt_n - (rt_root + rt_bit);
        rt_root <= (rt_root >> 1) + rt_bit;
      end else begin
        rt_root <= rt_root >> 1;
      end
      rt_bit <= rt_bit >> 2;
      if (rt_bit == 64'd1) begin
        rt_busy   <= 1'b0;
        root_done <= 1'b1;
      end
    end
  end

  assign root = rt_root[31:0];

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.minimum    <= run_min;
      out_item.maximum    <= run_max;
      out_item.average    <= mean;
      out_item.deviation  <= (root[31:24] != '0) ? 24'hFFFFFF : root[23:0];
      out_item.overflowed <= dropped;
    end
  end

endmodule

// ----- rtl/core/mmms_checker.sv -----
module mmms_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input mmms_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mmms_pkg::out_item_t out_data
);

  // the set closes on a final request: input stalls next cycle
  a_close: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.final_sample |=> in_stall)
    else $error("input open after final request");

  // never accept input while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open with result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_data.minimum <= out_data.maximum && out_valid && !out_data.overflowed
    |-> out_data.minimum <= out_data.average)
    else $error("mean below minimum");

endmodule

bind min_max_mean_stddev_unit mmms_checker u_mmms_checker (.*);
